// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file of this project.
// Both macros expect clk_i to be visible where used; MPFB_ASSERT also needs rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, skipped while reset is asserted.
`define MPFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define MPFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants and command codes of the monochrome page frame buffer
// drawing engine.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  // Default geometry: 128 columns by 8 pages of 8 rows.
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Fixed field widths.
  localparam int MODE_W     = 3;
  localparam int COORD_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int COL_OUT_W  = 7;
  localparam int PAGE_OUT_W = 3;

  // Command codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HLINE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_VLINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

endpackage

// File: hw/rtl/mpfb_store.sv
// ----------------------------------------------------------------------------
// mpfb_store
// Single-port frame store: one byte written or read per cycle, read data
// registered (read-before-write on the same address).
// ----------------------------------------------------------------------------
module mpfb_store #(
  parameter int DEPTH = mpfb_pkg::COLUMNS_DEF * mpfb_pkg::PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic [$clog2(DEPTH)-1:0]    addr_i,
  input  logic                        we_i,
  input  logic [mpfb_pkg::BYTE_W-1:0] wdata_i,
  output logic [mpfb_pkg::BYTE_W-1:0] rdata_o
);

  logic [mpfb_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [mpfb_pkg::BYTE_W-1:0] rdata_q;

  // Write port and registered read port share one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mono_page_framebuffer_draw_top.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_top
// Drawing engine over a page-organized monochrome frame store: set pixel,
// horizontal and vertical lines, rectangle outline, clear and byte read.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Word
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o | mode, x/y first, x/y second
//   out     | output    | out_valid_o/out_ready_i | data_byte, column, page, error
//
// Each plotted pixel is a read-modify-write of the one store port: a read state,
// then a write state. Pixel and read commands, lines, rectangles and clear all
// end in ST_FINISH, as do range errors and undefined modes; a stalled output
// delays the posting of the result there.
// After reset a clearing pass over every store byte holds the input off.
// The next word is accepted once the result is posted, even while it waits.
module mono_page_framebuffer_draw_top #(
  parameter int COLUMNS = mpfb_pkg::COLUMNS_DEF,
  parameter int PAGES   = mpfb_pkg::PAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mpfb_pkg::MODE_W-1:0]     mode_i,
  input  logic [mpfb_pkg::COORD_W-1:0]    x_first_i,
  input  logic [mpfb_pkg::COORD_W-1:0]    y_first_i,
  input  logic [mpfb_pkg::COORD_W-1:0]    x_second_i,
  input  logic [mpfb_pkg::COORD_W-1:0]    y_second_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mpfb_pkg::BYTE_W-1:0]     data_byte_o,
  output logic [mpfb_pkg::COL_OUT_W-1:0]  column_o,
  output logic [mpfb_pkg::PAGE_OUT_W-1:0] page_o,
  output logic                            range_error_o
);

  localparam int ROWS        = PAGES * 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT_RD,
    ST_PLOT_WR,
    ST_READ_RD,
    ST_READ_TAKE,
    ST_FINISH
  } state_e;

  // Vertical runs step the row, horizontal runs step the column.
  typedef enum logic {
    PH_VERT,
    PH_HORZ
  } phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [mpfb_pkg::MODE_W-1:0]  mode_q;
  logic [mpfb_pkg::COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [mpfb_pkg::COORD_W-1:0] cnt_q, end_q;
  logic                         sel_q, dual_q, horz_next_q, clr_reply_q;
  logic [ADDR_W-1:0]            clr_cnt_q;

  logic [mpfb_pkg::BYTE_W-1:0]     res_data_q;
  logic [mpfb_pkg::COL_OUT_W-1:0]  res_col_q;
  logic [mpfb_pkg::PAGE_OUT_W-1:0] res_page_q;
  logic                            res_err_q;

  logic                            out_valid_q;
  logic [mpfb_pkg::BYTE_W-1:0]     out_data_q;
  logic [mpfb_pkg::COL_OUT_W-1:0]  out_col_q;
  logic [mpfb_pkg::PAGE_OUT_W-1:0] out_page_q;
  logic                            out_err_q;

  logic [mpfb_pkg::COORD_W-1:0] cur_x, cur_y;
  logic [ADDR_W-1:0]            pt_addr, mem_addr;
  logic                         mem_we;
  logic [mpfb_pkg::BYTE_W-1:0]  mem_wdata, mem_rdata, plot_byte;
  logic                         x1_ok, y1_ok, x2_ok, y2_ok;
  logic                         in_acc;

  // Current point of the run and its byte address in the store.
  always_comb begin
    if (phase_q == PH_VERT) begin
      cur_x = sel_q ? x2_q : x1_q;
      cur_y = cnt_q;
    end else begin
      cur_x = cnt_q;
      cur_y = sel_q ? y2_q : y1_q;
    end
    pt_addr   = ADDR_W'(int'(cur_x) * PAGES + int'(cur_y[7:3]));
    plot_byte = mem_rdata | (mpfb_pkg::BYTE_W'(1) << cur_y[2:0]);
  end

  // Store port control: sweep address while clearing, point address otherwise.
  always_comb begin
    mem_addr  = (state_q == ST_CLEAR) ? clr_cnt_q : pt_addr;
    mem_we    = (state_q == ST_CLEAR) || (state_q == ST_PLOT_WR);
    mem_wdata = (state_q == ST_CLEAR) ? '0 : plot_byte;
  end

  mpfb_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Range checks on the incoming coordinates.
  assign x1_ok  = int'(x_first_i) < COLUMNS;
  assign x2_ok  = int'(x_second_i) < COLUMNS;
  assign y1_ok  = int'(y_first_i) < ROWS;
  assign y2_ok  = int'(y_second_i) < ROWS;
  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  // Sequencer: decodes a command, walks its pixels and posts the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_VERT;
      sel_q       <= 1'b0;
      dual_q      <= 1'b0;
      horz_next_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
            clr_cnt_q <= '0;
            state_q   <= clr_reply_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            mode_q      <= mode_i;
            x1_q        <= x_first_i;
            y1_q        <= y_first_i;
            x2_q        <= x_second_i;
            y2_q        <= y_second_i;
            sel_q       <= 1'b0;
            dual_q      <= 1'b0;
            horz_next_q <= 1'b0;
            phase_q     <= PH_VERT;
            cnt_q       <= y_first_i;
            end_q       <= y_first_i;
            res_data_q  <= '0;
            res_col_q   <= '0;
            res_page_q  <= '0;
            res_err_q   <= 1'b0;
            state_q     <= ST_FINISH;
            case (mode_i)
              mpfb_pkg::MODE_PIXEL: begin
                if (!(x1_ok && y1_ok)) begin
                  res_err_q <= 1'b1;
                end else begin
                  res_col_q  <= x_first_i[6:0];
                  res_page_q <= y_first_i[5:3];
                  state_q    <= ST_PLOT_RD;
                end
              end
              mpfb_pkg::MODE_HLINE: begin
                if (!y1_ok) begin
                  res_err_q <= 1'b1;
                end else begin
                  phase_q <= PH_HORZ;
                  cnt_q   <= '0;
                  end_q   <= mpfb_pkg::COORD_W'(COLUMNS - 1);
                  state_q <= ST_PLOT_RD;
                end
              end
              mpfb_pkg::MODE_VLINE: begin
                if (!x1_ok) begin
                  res_err_q <= 1'b1;
                end else begin
                  cnt_q   <= '0;
                  end_q   <= mpfb_pkg::COORD_W'(ROWS - 1);
                  state_q <= ST_PLOT_RD;
                end
              end
              mpfb_pkg::MODE_RECT: begin
                dual_q <= 1'b1;
                if (!(x1_ok && x2_ok && y1_ok && y2_ok)) begin
                  res_err_q <= 1'b1;
                end else if (y_first_i <= y_second_i) begin
                  // Sides first, then top and bottom if the span is not reversed.
                  end_q       <= y_second_i;
                  horz_next_q <= x_first_i <= x_second_i;
                  state_q     <= ST_PLOT_RD;
                end else if (x_first_i <= x_second_i) begin
                  phase_q <= PH_HORZ;
                  cnt_q   <= x_first_i;
                  end_q   <= x_second_i;
                  state_q <= ST_PLOT_RD;
                end
              end
              mpfb_pkg::MODE_CLEAR: begin
                clr_reply_q <= 1'b1;
                clr_cnt_q   <= '0;
                state_q     <= ST_CLEAR;
              end
              mpfb_pkg::MODE_READ: begin
                if (!(x1_ok && y1_ok)) begin
                  res_err_q <= 1'b1;
                end else begin
                  res_col_q  <= x_first_i[6:0];
                  res_page_q <= y_first_i[5:3];
                  state_q    <= ST_READ_RD;
                end
              end
              default: begin
                state_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_PLOT_RD: begin
          state_q <= ST_PLOT_WR;
        end
        ST_PLOT_WR: begin
          if (mode_q == mpfb_pkg::MODE_PIXEL) begin
            res_data_q <= plot_byte;
          end
          state_q <= ST_PLOT_RD;
          if (dual_q && !sel_q) begin
            sel_q <= 1'b1;
          end else begin
            sel_q <= 1'b0;
            if (cnt_q != end_q) begin
              cnt_q <= cnt_q + 1'b1;
            end else if (horz_next_q) begin
              horz_next_q <= 1'b0;
              phase_q     <= PH_HORZ;
              cnt_q       <= x1_q;
              end_q       <= x2_q;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_READ_RD: begin
          state_q <= ST_READ_TAKE;
        end
        ST_READ_TAKE: begin
          res_data_q <= mem_rdata;
          state_q    <= ST_FINISH;
        end
        ST_FINISH: begin
          // Post the result once the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_data_q;
            out_col_q   <= res_col_q;
            out_page_q  <= res_page_q;
            out_err_q   <= res_err_q;
            clr_reply_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = out_data_q;
  assign column_o      = out_col_q;
  assign page_o        = out_page_q;
  assign range_error_o = out_err_q;

endmodule

// File: hw/rtl/mpfb_checker.sv
// ----------------------------------------------------------------------------
// mpfb_checker
// Port-level checks of the drawing engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpfb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [mpfb_pkg::BYTE_W-1:0]     data_byte_o,
  input logic [mpfb_pkg::COL_OUT_W-1:0]  column_o,
  input logic [mpfb_pkg::PAGE_OUT_W-1:0] page_o,
  input logic                            range_error_o
);

  localparam int PAYLOAD_W = mpfb_pkg::BYTE_W + mpfb_pkg::COL_OUT_W + mpfb_pkg::PAGE_OUT_W;

  logic [PAYLOAD_W:0]   out_word;
  logic [PAYLOAD_W-1:0] err_payload;
  logic                 out_stall, in_acc, err_word;

  // Result word as one vector, and the handshake conditions used below.
  assign out_word    = {data_byte_o, column_o, page_o, range_error_o};
  assign err_payload = {data_byte_o, column_o, page_o};
  assign out_stall   = out_valid_o && !out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign err_word    = out_valid_o && range_error_o;

  // A stalled result word holds its payload.
  `MPFB_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_word), "stalled word changed")

  // One command at a time: the engine is busy right after accepting a word.
  `MPFB_ASSERT(a_busy_after_accept, in_acc |=> !in_ready_o, "ready right after accepting a word")

  // A rejected command reports no byte, column or page.
  `MPFB_ASSERT(a_error_zero, err_word |-> err_payload == '0, "range error with nonzero fields")

  // Reset keeps both channels quiet; the store is cleared after it is released.
  `MPFB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_ready_o, "handshake in reset")

endmodule

bind mono_page_framebuffer_draw_top mpfb_checker u_mpfb_checker (.*);
